### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define UDCP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define UDCP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define UDCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/udcp_pkg.sv
// ----------------------------------------------------------------------------
// udcp_pkg
// Types and constants of the UART duty command parser.
// ----------------------------------------------------------------------------
package udcp_pkg;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic        echo_valid;
      logic [7:0]  echo_byte;
      logic [3:0]  event_res;
      logic [15:0] pulse_width;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      EV_NONE    = 4'd0,
      EV_EMPTY   = 4'd1,
      EV_LONG    = 4'd2,
      EV_BLANK   = 4'd3,
      EV_OK      = 4'd4,
      EV_MISSING = 4'd5,
      EV_INVALID = 4'd6,
      EV_RANGE   = 4'd7,
      EV_UNKNOWN = 4'd8
   } event_code_type;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_KEY,
      PH_GAP,
      PH_NUMSTART,
      PH_NUMBODY,
      PH_DONE
   } phase_type;

   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_MIN    = 2'd1;
   localparam logic [1:0] CSR_MAX    = 2'd2;

   localparam logic [15:0] PERIOD_RESET = 16'd5581;
   localparam logic [6:0]  MIN_RESET    = 7'd5;
   localparam logic [6:0]  MAX_RESET    = 7'd96;
   localparam logic [15:0] PULSE_RESET  = 16'd1674;

   // "PSYN", first letter at index 0
   localparam logic [3:0][7:0] KEYWORD = {8'h4E, 8'h59, 8'h53, 8'h50};

   localparam int PERCENT_FULL = 100;
   localparam int RECIP_SHIFT  = 23;
   localparam int RECIP_W      = 24;

   typedef logic [PERCENT_FULL:0][RECIP_W-1:0] recip_lut_type;

   // ceil(p * 2^23 / 100): floor(period * lut[p] >> 23) == period * p / 100
   function automatic recip_lut_type build_recip_lut();
      recip_lut_type lut;
      for (int i = 0; i <= PERCENT_FULL; i++) begin
         lut[i] = RECIP_W'(((64'(i) << RECIP_SHIFT) + 64'(PERCENT_FULL - 1)) / PERCENT_FULL);
      end
      return lut;
   endfunction

   localparam recip_lut_type RECIP_LUT = build_recip_lut();

endpackage

### rtl/uart_duty_command_parser.sv
// Latency: a result item is offered the cycle after its input item is accepted when the result queue is empty.
// Throughput: one item per cycle while the result queue is not full; the parse state updates in the accept cycle.
// A two-entry result queue keeps req_ready high while one result waits.
// Reset (synchronous, active high) clears the line parse and the queue,
// loads pulse 1674 and the registers with period 5581, min 5, max 96.
// ----------------------------------------------------------------------------
// uart_duty_command_parser
// Echoes UART bytes and parses PSYN duty commands into a PWM pulse width.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_duty_command_parser
   import udcp_pkg::*;
#(
   parameter int LINE_BUFFER_SIZE = 128
) (
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,

   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,

   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   logic [15:0]     period_ff;
   logic [6:0]      min_ff, max_ff;
   logic            csr_wr;
   logic [1:0]      csr_index;

   logic            take, give;
   rsp_payload_type line_rsp;
   rsp_payload_type head_ff, head_in, tail_ff, tail_in;
   logic [1:0]      cnt_ff, cnt_in;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         min_ff    <= MIN_RESET;
         max_ff    <= MAX_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_PERIOD: period_ff <= csr_pwdata[15:0];
            CSR_MIN:    min_ff    <= csr_pwdata[6:0];
            CSR_MAX:    max_ff    <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_PERIOD: csr_prdata = {16'd0, period_ff};
         CSR_MIN:    csr_prdata = {25'd0, min_ff};
         CSR_MAX:    csr_prdata = {25'd0, max_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // parser
   assign take = req_valid && req_ready;

   udcp_line #(
      .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
   ) u_line (
      .clock       (clock),
      .reset       (reset),
      .item_take   (take),
      .req_data    (req_data),
      .pwm_period  (period_ff),
      .min_percent (min_ff),
      .max_percent (max_ff),
      .rsp_data    (line_rsp)
   );

   // two-entry result queue
   assign req_ready = (cnt_ff != 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign give      = rsp_valid && rsp_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (take && !give) begin
         if (cnt_ff == 2'd0) begin
            head_in = line_rsp;
         end else begin
            tail_in = line_rsp;
         end
         cnt_in = cnt_ff + 2'd1;
      end else if (give && !take) begin
         head_in = tail_ff;
         cnt_in  = cnt_ff - 2'd1;
      end else if (give && take) begin
         if (cnt_ff == 2'd1) begin
            head_in = line_rsp;
         end else begin
            head_in = tail_ff;
            tail_in = line_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `UDCP_ASSERT(a_cnt_bound, clock, reset, cnt_ff != 2'd3, "result queue count out of range")
   `UDCP_ASSERT_NEXT(a_take_shows, clock, reset, take && !give && (cnt_ff == 2'd0), rsp_valid && (rsp_data == $past(line_rsp)), "accepted item not presented")
   `UDCP_ASSERT_NEXT(a_period_wr, clock, reset, csr_wr && (csr_index == CSR_PERIOD), period_ff == $past(csr_pwdata[15:0]), "period write lost")

endmodule

### rtl/udcp_line.sv
// ----------------------------------------------------------------------------
// udcp_line
// Per-byte line parser and pulse register; one item per cycle while item_take is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udcp_line
   import udcp_pkg::*;
#(
   parameter int LINE_BUFFER_SIZE = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_take,
   input  req_payload_type req_data,
   input  logic [15:0]     pwm_period,
   input  logic [6:0]      min_percent,
   input  logic [6:0]      max_percent,
   output rsp_payload_type rsp_data
);

   localparam int LEN_W = $clog2(LINE_BUFFER_SIZE);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_SIZE - 1);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;
   localparam logic [6:0] NUM_SAT  = 7'd127;
   localparam logic [6:0] PCT_MAX  = 7'(PERCENT_FULL);
   localparam logic [2:0] KW_LEN   = 3'd4;

   logic [LEN_W-1:0] line_length_ff, line_length_in;
   phase_type        phase_ff, phase_in;
   logic [2:0]       kw_matched_ff, kw_matched_in;
   logic             kw_mismatch_ff, kw_mismatch_in;
   logic             num_negative_ff, num_negative_in;
   logic [6:0]       num_value_ff, num_value_in;
   logic             digits_seen_ff, digits_seen_in;
   logic             num_bad_ff, num_bad_in;
   logic [15:0]      pulse_ff, pulse_in;

   logic [7:0]       c;
   logic             is_ws, is_delim, is_digit, is_eol;
   logic [7:0]       upper;
   logic [10:0]      digit_sum;
   logic [6:0]       digit_value;
   phase_type        eff_phase;
   event_code_type   fin_ev, ev;
   logic             clear;
   logic [6:0]       pct;
   logic [39:0]      product;
   logic [15:0]      quot, clamped, pulse_calc;

   assign c        = req_data.rx_byte;
   assign is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign is_delim = (c == CH_SPACE) || (c == CH_TAB);
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_eol   = (c == CH_CR) || (c == CH_LF);
   assign upper    = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? c - CASE_GAP : c;

   assign digit_sum   = ({4'd0, num_value_ff} << 3) + ({4'd0, num_value_ff} << 1)
                        + {7'd0, c[3:0]};
   assign digit_value = (digit_sum > {4'd0, NUM_SAT}) ? NUM_SAT : digit_sum[6:0];

   // pulse = period * pct / 100 through the reciprocal table, limited to period - 1 and raised to at least 1
   assign pct        = (num_value_ff > PCT_MAX) ? PCT_MAX : num_value_ff;
   assign product    = {24'd0, pwm_period} * {16'd0, RECIP_LUT[pct]};
   assign quot       = product[RECIP_SHIFT+15:RECIP_SHIFT];
   assign clamped    = (quot >= pwm_period) ? pwm_period - 16'd1 : quot;
   assign pulse_calc = (clamped == 16'd0) ? 16'd1 : clamped;

   always_comb begin
      if (phase_ff == PH_LEAD) begin
         fin_ev = EV_BLANK;
      end else if (kw_mismatch_ff || (kw_matched_ff != KW_LEN)) begin
         fin_ev = EV_UNKNOWN;
      end else if ((phase_ff == PH_KEY) || (phase_ff == PH_GAP)) begin
         fin_ev = EV_MISSING;
      end else if (num_bad_ff || !digits_seen_ff) begin
         fin_ev = EV_INVALID;
      end else if (num_negative_ff && (num_value_ff != 7'd0)) begin
         fin_ev = EV_RANGE;
      end else if ((num_value_ff < min_percent) || (num_value_ff > max_percent)) begin
         fin_ev = EV_RANGE;
      end else begin
         fin_ev = EV_OK;
      end
   end

   // leading whitespace and the gap fall through into the next phase
   always_comb begin
      if ((phase_ff == PH_LEAD) && !is_ws) begin
         eff_phase = PH_KEY;
      end else if ((phase_ff == PH_GAP) && !is_delim) begin
         eff_phase = PH_NUMSTART;
      end else begin
         eff_phase = phase_ff;
      end
   end

   always_comb begin
      line_length_in  = line_length_ff;
      phase_in        = eff_phase;
      kw_matched_in   = kw_matched_ff;
      kw_mismatch_in  = kw_mismatch_ff;
      num_negative_in = num_negative_ff;
      num_value_in    = num_value_ff;
      digits_seen_in  = digits_seen_ff;
      num_bad_in      = num_bad_ff;
      pulse_in        = pulse_ff;
      ev              = EV_NONE;
      clear           = 1'b0;

      if (req_data.command) begin
         clear = 1'b1;
      end else if (is_eol) begin
         clear = 1'b1;
         if (line_length_ff != '0) begin
            ev = fin_ev;
            if (fin_ev == EV_OK) begin
               pulse_in = pulse_calc;
            end
         end else begin
            ev = EV_EMPTY;
         end
      end else if (line_length_ff < LEN_LIMIT) begin
         line_length_in = line_length_ff + LEN_W'(1);
         case (eff_phase)
            PH_KEY: begin
               if (is_delim) begin
                  phase_in = (kw_mismatch_ff || (kw_matched_ff != KW_LEN)) ? PH_DONE : PH_GAP;
               end else if ((kw_matched_ff < KW_LEN) && (upper == KEYWORD[kw_matched_ff[1:0]])) begin
                  kw_matched_in = kw_matched_ff + 3'd1;
               end else begin
                  kw_mismatch_in = 1'b1;
               end
            end
            PH_NUMSTART: begin
               if (is_delim) begin
                  phase_in = PH_DONE;
               end else if ((c == CH_VT) || (c == CH_FF)) begin
                  phase_in = PH_NUMSTART;
               end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                  num_negative_in = (c == CH_MINUS);
                  phase_in        = PH_NUMBODY;
               end else begin
                  if (is_digit) begin
                     num_value_in   = digit_value;
                     digits_seen_in = 1'b1;
                  end else begin
                     num_bad_in = 1'b1;
                  end
                  phase_in = PH_NUMBODY;
               end
            end
            PH_NUMBODY: begin
               if (is_delim) begin
                  phase_in = PH_DONE;
               end else if (is_digit) begin
                  num_value_in   = digit_value;
                  digits_seen_in = 1'b1;
               end else begin
                  num_bad_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else begin
         clear = 1'b1;
         ev    = EV_LONG;
      end

      if (clear) begin
         line_length_in  = '0;
         phase_in        = PH_LEAD;
         kw_matched_in   = 3'd0;
         kw_mismatch_in  = 1'b0;
         num_negative_in = 1'b0;
         num_value_in    = 7'd0;
         digits_seen_in  = 1'b0;
         num_bad_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= '0;
         phase_ff        <= PH_LEAD;
         kw_matched_ff   <= 3'd0;
         kw_mismatch_ff  <= 1'b0;
         num_negative_ff <= 1'b0;
         num_value_ff    <= 7'd0;
         digits_seen_ff  <= 1'b0;
         num_bad_ff      <= 1'b0;
         pulse_ff        <= PULSE_RESET;
      end else if (item_take) begin
         line_length_ff  <= line_length_in;
         phase_ff        <= phase_in;
         kw_matched_ff   <= kw_matched_in;
         kw_mismatch_ff  <= kw_mismatch_in;
         num_negative_ff <= num_negative_in;
         num_value_ff    <= num_value_in;
         digits_seen_ff  <= digits_seen_in;
         num_bad_ff      <= num_bad_in;
         pulse_ff        <= pulse_in;
      end
   end

   assign rsp_data.echo_valid  = !req_data.command;
   assign rsp_data.echo_byte   = req_data.command ? 8'd0 : c;
   assign rsp_data.event_res   = ev;
   assign rsp_data.pulse_width = pulse_in;

   `UDCP_ASSERT_IMPLY(a_phase_has_len, clock, reset, phase_ff != PH_LEAD, line_length_ff != '0, "parse phase advanced on an empty line")
   `UDCP_ASSERT(a_kw_bound, clock, reset, kw_matched_ff <= KW_LEN, "keyword match count past keyword length")
   `UDCP_ASSERT_IMPLY(a_ok_pulse, clock, reset, item_take && (ev == EV_OK), (pulse_in != 16'd0) && (pulse_in != 16'hFFFF || pwm_period == 16'd0), "ok event with bad pulse")

endmodule
